@@ hdl/crcfa_pkg.sv @@
// Package for the CRC-8 frame append and check block.
// Holds the item type, the mode codes, the CRC constants and the byte update function.
// No dependencies.
package crcfa_pkg;

  localparam int CRC_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY_RESET  = 8'h91;
  localparam logic [CRC_W-1:0] EMPTY_FRAME_CRC = 8'hFF;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PAYLOAD  = 2'd0;
  localparam mode_t MODE_CLOSE_TX = 2'd1;
  localparam mode_t MODE_CLOSE_RX = 2'd2;
  localparam mode_t MODE_UNUSED   = 2'd3;

  typedef struct packed {
    mode_t            mode;
    logic [CRC_W-1:0] data_byte;
  } item_t;

  // Reflected CRC-8 update of one byte, one round per bit.
  function automatic logic [CRC_W-1:0] crc8_update(input logic [CRC_W-1:0] crc,
                                                   input logic [CRC_W-1:0] data,
                                                   input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] v;
    v = crc ^ data;
    for (int r = 0; r < CRC_W; r++) begin
      if (v[0]) begin
        v = v ^ poly;
      end
      v = v >> 1;
    end
    return v;
  endfunction

endpackage

@@ hdl/crcfa_in_stage.sv @@
// Input register stage of the CRC-8 frame block.
// Captures one item per cycle and holds it while the engine cannot take it.
// Depends on crcfa_pkg.
module crcfa_in_stage import crcfa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r,  item_nxt;
  logic  load;

  // Take a new item when the stage is empty or its item moves on this cycle.
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

@@ hdl/crcfa_engine.sv @@
// CRC engine and result register of the CRC-8 frame block.
// Keeps the running CRC and the frame flag, builds each result and registers it.
// Depends on crcfa_pkg.
module crcfa_engine import crcfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CRC_W-1:0] poly,
  input  logic             s1_valid,
  input  item_t            s1_item,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CRC_W-1:0] out_byte,
  output logic             out_is_checksum,
  output logic             out_mismatch,
  output logic             out_frame_end
);

  logic             has_r;
  logic [CRC_W-1:0] crc_val_r, crc_val_nxt;
  logic             has_nxt;
  logic             valid_r, valid_nxt;
  logic [CRC_W-1:0] byte_r, byte_nxt;
  logic             chk_r, chk_nxt;
  logic             mis_r, mis_nxt;
  logic             end_r, end_nxt;
  logic [CRC_W-1:0] close_crc;
  logic             step;

  assign advance   = !valid_r || !out_stall;
  assign step      = s1_valid && advance;
  assign close_crc = has_r ? crc_val_r : EMPTY_FRAME_CRC;

  always_comb begin
    crc_val_nxt = crc_val_r;
    has_nxt     = has_r;
    valid_nxt   = valid_r;
    byte_nxt    = byte_r;
    chk_nxt     = chk_r;
    mis_nxt     = mis_r;
    end_nxt     = end_r;
    if (advance) begin
      valid_nxt = 1'b0;
    end
    if (step) begin
      case (s1_item.mode) inside
        MODE_PAYLOAD: begin
          crc_val_nxt = crc8_update(crc_val_r, s1_item.data_byte, poly);
          has_nxt     = 1'b1;
          valid_nxt   = 1'b1;
          byte_nxt    = s1_item.data_byte;
          chk_nxt     = 1'b0;
          mis_nxt     = 1'b0;
          end_nxt     = 1'b0;
        end
        MODE_CLOSE_TX, MODE_CLOSE_RX: begin
          crc_val_nxt = '0;
          has_nxt     = 1'b0;
          valid_nxt   = 1'b1;
          byte_nxt    = close_crc;
          chk_nxt     = 1'b1;
          mis_nxt     = (s1_item.mode == MODE_CLOSE_RX) && (s1_item.data_byte != close_crc);
          end_nxt     = 1'b1;
        end
        default: begin
          // drop: no result, state untouched
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_val_r <= '0;
      has_r     <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      crc_val_r <= crc_val_nxt;
      has_r     <= has_nxt;
      valid_r   <= valid_nxt;
    end
    byte_r <= byte_nxt;
    chk_r  <= chk_nxt;
    mis_r  <= mis_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_is_checksum = chk_r;
  assign out_mismatch    = mis_r;
  assign out_frame_end   = end_r;

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (s1_item.mode == MODE_CLOSE_TX || s1_item.mode == MODE_CLOSE_RX)
    |=> crc_val_r == '0 && !has_r)
    else $error("frame close did not clear the CRC state");

  a_payload_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step && s1_item.mode == MODE_PAYLOAD |=> has_r && valid_r && !end_r)
    else $error("payload byte did not mark the frame");

  a_mismatch_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && mis_r |-> chk_r && end_r)
    else $error("mismatch flagged on a result that is not a checksum");

  a_unused_drops: assert property (@(posedge clk) disable iff (!rst_n)
    step && s1_item.mode == MODE_UNUSED |=> !valid_r && $stable(crc_val_r))
    else $error("unused mode produced a result or changed the CRC");

endmodule

@@ hdl/crc8_frame_append_and_check.sv @@
// CRC-8 frame append and check: top level, polynomial register and stage wiring.
// Path: each item passes the input register, then the result register; a result-channel stall can hold it in between.
// Throughput: one item per cycle while out_stall is low; the byte update is one pass of XOR logic between
// the input register and the result register.
// Reset (rst_n low, synchronous): pipeline empty, running CRC 0, no frame bytes,
// polynomial 0x91. Items with the unused mode are accepted and dropped.
module crc8_frame_append_and_check import crcfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // configuration: the polynomial register
  input  logic             cfg_wr_en,
  input  logic [CRC_W-1:0] cfg_wr_data,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [CRC_W-1:0] in_data_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CRC_W-1:0] out_byte,
  output logic             out_is_checksum,
  output logic             out_mismatch,
  output logic             out_frame_end
);

  logic [CRC_W-1:0] poly_r, poly_nxt;
  item_t            in_item;
  item_t            s1_item;
  logic             s1_valid;
  logic             advance;

  // Hold the polynomial; writes must arrive only while the block is idle, which the block does not enforce.
  always_comb begin
    poly_nxt = poly_r;
    if (cfg_wr_en) begin
      poly_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= CRC_POLY_RESET;
    end else begin
      poly_r <= poly_nxt;
    end
  end

  // Pack the input fields into one item.
  assign in_item.mode      = in_mode;
  assign in_item.data_byte = in_data_byte;

  // Stage one: register the incoming item; it stalls only when the result
  // register is full and the downstream side holds it.
  crcfa_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Stage two: update or close the running CRC and register the result.
  crcfa_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .poly            (poly_r),
    .s1_valid        (s1_valid),
    .s1_item         (s1_item),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_checksum (out_is_checksum),
    .out_mismatch    (out_mismatch),
    .out_frame_end   (out_frame_end)
  );

endmodule

@@ test/crc8_frame_checker.sv @@
// Result checker for the CRC-8 frame append and check block.
// Watches the config, input and result channels, predicts each result and compares it.
// Depends on crcfa_pkg for the byte width, the mode codes and the CRC constants.
module crc8_frame_checker import crcfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CRC_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  mode_t            in_mode,
  input  logic [CRC_W-1:0] in_data_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CRC_W-1:0] out_byte,
  input  logic             out_is_checksum,
  input  logic             out_mismatch,
  input  logic             out_frame_end,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [CRC_W-1:0] value;
    logic             is_checksum;
    logic             mismatch;
    logic             frame_end;
  } link_byte_t;

  link_byte_t       awaited_bytes[$];
  logic [CRC_W-1:0] poly;
  logic [CRC_W-1:0] frame_crc;
  logic             frame_open;

  // Shifting distributes over XOR, so fold the polynomial in pre-shifted.
  function automatic logic [CRC_W-1:0] crc8_advance(input logic [CRC_W-1:0] acc,
                                                    input logic [CRC_W-1:0] din,
                                                    input logic [CRC_W-1:0] p);
    logic [CRC_W-1:0] v;
    v = acc ^ din;
    for (int i = 0; i < CRC_W; i++) begin
      v = (v >> 1) ^ (v[0] ? (p >> 1) : '0);
    end
    return v;
  endfunction

  always @(posedge clk) begin
    link_byte_t want;
    link_byte_t got;
    if (!rst_n) begin
      poly       = CRC_POLY_RESET;
      frame_crc  = '0;
      frame_open = 1'b0;
      awaited_bytes.delete();
      pending   <= 0;
    end else begin
      if (cfg_wr_en) begin
        poly = cfg_wr_data;
      end

      if (out_valid && !out_stall) begin
        got.value       = out_byte;
        got.is_checksum = out_is_checksum;
        got.mismatch    = out_mismatch;
        got.frame_end   = out_frame_end;
        if (awaited_bytes.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result: byte %02h chk %0b mis %0b end %0b",
                     got.value, got.is_checksum, got.mismatch, got.frame_end);
          end
          errors <= errors + 1;
        end else begin
          want = awaited_bytes.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display({"result mismatch: expected byte %02h chk %0b mis %0b end %0b,",
                        " got byte %02h chk %0b mis %0b end %0b"},
                       want.value, want.is_checksum, want.mismatch, want.frame_end,
                       got.value, got.is_checksum, got.mismatch, got.frame_end);
            end
            errors <= errors + 1;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_mode) inside
          MODE_PAYLOAD: begin
            frame_crc  = crc8_advance(frame_crc, in_data_byte, poly);
            frame_open = 1'b1;
            want.value       = in_data_byte;
            want.is_checksum = 1'b0;
            want.mismatch    = 1'b0;
            want.frame_end   = 1'b0;
            awaited_bytes.push_back(want);
          end
          MODE_CLOSE_TX, MODE_CLOSE_RX: begin
            want.value       = frame_open ? frame_crc : EMPTY_FRAME_CRC;
            want.is_checksum = 1'b1;
            want.mismatch    = (in_mode == MODE_CLOSE_RX) && (in_data_byte != want.value);
            want.frame_end   = 1'b1;
            awaited_bytes.push_back(want);
            frame_crc  = '0;
            frame_open = 1'b0;
          end
          default: ;  // drop: unused mode leaves no result and no state change
        endcase
      end

      pending <= awaited_bytes.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the CRC-8 frame append and check block.
// Drives framed byte streams, stalls and polynomial writes; crc8_frame_checker does the checking.
// Depends on crcfa_pkg, crc8_frame_append_and_check and crc8_frame_checker.
module tb;
  import crcfa_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int HOLD_CYCLES = 80;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_wr_en    = 1'b0;
  logic [CRC_W-1:0] cfg_wr_data  = '0;
  logic             in_valid     = 1'b0;
  mode_t            in_mode      = MODE_PAYLOAD;
  logic [CRC_W-1:0] in_data_byte = '0;
  logic             out_stall    = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic [CRC_W-1:0] out_byte;
  logic             out_is_checksum;
  logic             out_mismatch;
  logic             out_frame_end;

  int errors;
  int pending;

  // Idle odds in percent per cycle, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-off, run by its own process below.
  logic hold_go   = 1'b0;
  logic hold_recv = 1'b0;

  // Sender-side CRC of the open frame, only used to build correct checksum bytes.
  logic [CRC_W-1:0] tx_poly = CRC_POLY_RESET;
  logic [CRC_W-1:0] tx_crc  = '0;
  logic             tx_open = 1'b0;
  int               items_sent = 0;

  crc8_frame_append_and_check dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_checksum (out_is_checksum),
    .out_mismatch    (out_mismatch),
    .out_frame_end   (out_frame_end)
  );

  crc8_frame_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_checksum (out_is_checksum),
    .out_mismatch    (out_mismatch),
    .out_frame_end   (out_frame_end),
    .errors          (errors),
    .pending         (pending)
  );

  always #1 clk = ~clk;

  // Receiver: stall at random, or hard for the whole hold-off stretch.
  always @(posedge clk) begin
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // Hold the result channel off for a long stretch once asked, so the pipeline
  // backs up and the block has to stall its input while the sender keeps offering.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_recv <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_recv <= 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("crc8_frame_append_and_check test failed");
    $finish;
  end

  function automatic logic [CRC_W-1:0] frame_crc_step(input logic [CRC_W-1:0] acc,
                                                      input logic [CRC_W-1:0] din);
    logic [CRC_W-1:0] v;
    v = acc ^ din;
    repeat (CRC_W) begin
      if (v[0]) begin
        v = v ^ tx_poly;
      end
      v = v >> 1;
    end
    return v;
  endfunction

  // Offer one item and hold it until accepted. Valid stays high on return, so a
  // back-to-back item follows without a gap; idle cycles are where it drops.
  task automatic send_item(input mode_t m, input logic [CRC_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_data_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Track the frame the same way the block should, for checksum building.
    case (m) inside
      MODE_PAYLOAD: begin
        tx_crc  = frame_crc_step(tx_crc, d);
        tx_open = 1'b1;
        items_sent++;
      end
      MODE_CLOSE_TX, MODE_CLOSE_RX: begin
        tx_crc  = '0;
        tx_open = 1'b0;
        items_sent++;
      end
      default: ;
    endcase
  endtask

  // Checksum byte that an incoming frame closed now would match.
  function automatic logic [CRC_W-1:0] good_checksum();
    return tx_open ? tx_crc : EMPTY_FRAME_CRC;
  endfunction

  // One frame with random content: n_bytes payload bytes with occasional unused-mode
  // noise, then an outgoing close or an incoming close with a good or a bad checksum.
  task automatic send_frame(input int n_bytes);
    logic [CRC_W-1:0] chk;
    repeat (n_bytes) begin
      if ($urandom_range(19) == 0) begin
        send_item(MODE_UNUSED, CRC_W'($urandom_range(255)));
      end
      send_item(MODE_PAYLOAD, CRC_W'($urandom_range(255)));
    end
    if ($urandom_range(2) == 0) begin
      send_item(MODE_CLOSE_TX, CRC_W'($urandom_range(255)));
    end else begin
      chk = good_checksum();
      case ($urandom_range(3))
        0: chk = CRC_W'($urandom_range(255));
        1: chk = chk ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
        default: ;  // keep it correct
      endcase
      send_item(MODE_CLOSE_RX, chk);
    end
  endtask

  // Write the polynomial with the block idle: drop valid, drain every expected
  // result, then give in-flight unused-mode items time to fall out.
  task automatic write_poly(input logic [CRC_W-1:0] p);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tx_poly = p;
  endtask

  initial begin
    logic [CRC_W-1:0] poly_plan [PHASES];
    int               target;

    poly_plan[0] = 8'h00;
    poly_plan[1] = 8'hFF;
    poly_plan[2] = 8'h8C;
    poly_plan[3] = 8'h07;
    poly_plan[4] = CRC_W'($urandom_range(255));
    poly_plan[5] = CRC_W'($urandom_range(255));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset polynomial.
    send_item(MODE_CLOSE_TX, 8'h00);             // empty outgoing frame
    send_item(MODE_CLOSE_RX, EMPTY_FRAME_CRC);   // empty incoming frame, checksum matches
    send_item(MODE_CLOSE_RX, 8'h00);             // empty incoming frame, checksum wrong
    send_item(MODE_PAYLOAD, 8'h00);
    send_item(MODE_PAYLOAD, 8'hFF);
    send_item(MODE_CLOSE_TX, 8'h00);
    send_item(MODE_PAYLOAD, 8'hA5);
    send_item(MODE_PAYLOAD, 8'h5A);
    send_item(MODE_CLOSE_RX, good_checksum());
    send_item(MODE_PAYLOAD, 8'h80);
    send_item(MODE_PAYLOAD, 8'h01);
    send_item(MODE_CLOSE_RX, ~good_checksum());
    send_item(MODE_UNUSED, 8'hFF);               // dropped, state untouched
    send_item(MODE_PAYLOAD, 8'h3C);
    send_item(MODE_UNUSED, 8'h00);
    send_item(MODE_CLOSE_TX, 8'hFF);             // data ignored on outgoing close
    send_item(MODE_PAYLOAD, 8'hFF);
    send_item(MODE_PAYLOAD, 8'hFF);
    send_item(MODE_PAYLOAD, 8'h00);
    send_item(MODE_CLOSE_RX, good_checksum());
    send_item(MODE_CLOSE_RX, 8'hFE);             // empty frame right after a close

    // Random phases: new polynomial each, idle pattern receiver-heavy, then
    // sender-heavy, then none (with the long hold-off at its start).
    for (int ph = 0; ph < PHASES; ph++) begin
      write_poly(poly_plan[ph]);
      case (ph / 2)
        0: begin send_idle_pct = 32; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 4) begin
        hold_go <= 1'b1;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // Mostly short frames, now and then a long one.
        if ($urandom_range(15) == 0) begin
          send_frame($urandom_range(9, 40));
        end else begin
          send_frame($urandom_range(0, 8));
        end
      end
    end

    // Drain, then let the pipeline settle before the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("crc8_frame_append_and_check test passed");
    end else begin
      $display("crc8_frame_append_and_check test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/crcfa_pkg.sv
hdl/crcfa_in_stage.sv
hdl/crcfa_engine.sv
hdl/crc8_frame_append_and_check.sv
test/crc8_frame_checker.sv
test/tb.sv
